// ----- hw/rtl/periodic_timer_task_bank_macros.svh -----
// assertion macros for the timer bank checker
`ifndef PERIODIC_TIMER_TASK_BANK_MACROS_SVH
`define PERIODIC_TIMER_TASK_BANK_MACROS_SVH

// same-cycle implication, off while reset is low
`define PTB_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("timer bank check failed");

// next-cycle implication, off while reset is low
`define PTB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("timer bank check failed");

`endif

// ----- hw/rtl/ptb_pkg.sv -----
// shared types and constants of the periodic timer bank
`timescale 1ns / 1ps

package ptb_pkg;

    // defaults for the top level parameters
    localparam int NUM_TIMERS_DEF  = 8;
    localparam int COUNT_WIDTH_DEF = 32;

    // fixed field widths of the ports
    localparam int OP_W    = 2;
    localparam int INDEX_W = 6;
    localparam int LIMIT_W = 32;

    // op codes on the input word
    localparam logic [OP_W-1:0] OP_TICK  = 2'd0;
    localparam logic [OP_W-1:0] OP_START = 2'd1;
    localparam logic [OP_W-1:0] OP_STOP  = 2'd2;

    // command queue between front and back
    localparam int QPTR_W      = 1;
    localparam int QUEUE_DEPTH = 2 ** QPTR_W;

    typedef enum logic [1:0] {
        CMD_TICK  = 2'd0,
        CMD_START = 2'd1,
        CMD_STOP  = 2'd2
    } cmd_kind_t;

    // head of the command queue as seen by the back end
    typedef struct packed {
        logic      valid;
        cmd_kind_t kind;
        logic      act;
    } cmd_ctl_t;

endpackage

// ----- hw/rtl/ptb_front.sv -----
// front end: accepts words, drops no-op items, queues commands
`timescale 1ns / 1ps

module ptb_front #(
    parameter int NUM_TIMERS  = ptb_pkg::NUM_TIMERS_DEF,
    parameter int COUNT_WIDTH = ptb_pkg::COUNT_WIDTH_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    input  logic [ptb_pkg::OP_W-1:0]             op,
    input  logic [ptb_pkg::INDEX_W-1:0]          timer_index,
    input  logic [ptb_pkg::LIMIT_W-1:0]          count_limit,
    input  logic                                 has_action,
    output logic                                 busy,
    output ptb_pkg::cmd_ctl_t                    cmd,
    output logic [((NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1)-1:0] cmd_idx,
    output logic [COUNT_WIDTH-1:0]               cmd_limit,
    input  logic                                 cmd_pop
);
    import ptb_pkg::*;

    localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam int CNT_W = QPTR_W + 1;

    cmd_kind_t          kind_q [QUEUE_DEPTH];
    logic               act_q  [QUEUE_DEPTH];
    logic [IDX_W-1:0]   idx_q  [QUEUE_DEPTH];
    logic [COUNT_WIDTH-1:0] lim_q [QUEUE_DEPTH];

    logic [QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   fill_reg, fill_next;

    logic               accept;
    logic               in_range;
    logic               keep;
    logic               pop;
    cmd_kind_t          in_kind;

    // classify the incoming word
    assign accept   = start && !busy;
    assign in_range = {1'b0, timer_index} < (INDEX_W + 1)'(NUM_TIMERS);
    assign keep     = accept && ((op == OP_TICK) ||
                      (((op == OP_START) || (op == OP_STOP)) && in_range));
    assign in_kind  = (op == OP_TICK)  ? CMD_TICK :
                      (op == OP_START) ? CMD_START : CMD_STOP;

    // queue status
    assign busy = (fill_reg == CNT_W'(QUEUE_DEPTH));
    assign pop  = cmd.valid && cmd_pop;

    assign cmd.valid = (fill_reg != '0);
    assign cmd.kind  = kind_q[rd_ptr_reg];
    assign cmd.act   = act_q[rd_ptr_reg];
    assign cmd_idx   = idx_q[rd_ptr_reg];
    assign cmd_limit = lim_q[rd_ptr_reg];

    // pointer and fill updates
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (keep)
        begin
            wr_ptr_next = QPTR_W'(wr_ptr_reg + 1'b1);
        end
        if (pop)
        begin
            rd_ptr_next = QPTR_W'(rd_ptr_reg + 1'b1);
        end
        if (keep && !pop)
        begin
            fill_next = CNT_W'(fill_reg + 1'b1);
        end
        else if (pop && !keep)
        begin
            fill_next = CNT_W'(fill_reg - 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (keep)
        begin
            kind_q[wr_ptr_reg] <= in_kind;
            act_q[wr_ptr_reg]  <= has_action;
            idx_q[wr_ptr_reg]  <= timer_index[IDX_W-1:0];
            lim_q[wr_ptr_reg]  <= COUNT_WIDTH'(count_limit);
        end
    end

endmodule

// ----- hw/rtl/ptb_back.sv -----
// back end: timer state, tick walk over the count memories, fire words
`timescale 1ns / 1ps

module ptb_back #(
    parameter int NUM_TIMERS  = ptb_pkg::NUM_TIMERS_DEF,
    parameter int COUNT_WIDTH = ptb_pkg::COUNT_WIDTH_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  ptb_pkg::cmd_ctl_t                    cmd,
    input  logic [((NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1)-1:0] cmd_idx,
    input  logic [COUNT_WIDTH-1:0]               cmd_limit,
    output logic                                 cmd_pop,
    output logic                                 strobe,
    output logic [ptb_pkg::INDEX_W-1:0]          fired_index,
    output logic                                 last
);
    import ptb_pkg::*;

    localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_TIMERS - 1);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_WALK  = 2'd1;
    localparam logic [1:0] S_DRAIN = 2'd2;
    localparam logic [1:0] S_FINAL = 2'd3;

    // count and limit memories, guarded by the armed bits
    logic [COUNT_WIDTH-1:0] cnt_mem [NUM_TIMERS];
    logic [COUNT_WIDTH-1:0] lim_mem [NUM_TIMERS];
    logic [COUNT_WIDTH-1:0] cnt_rd_reg;
    logic [COUNT_WIDTH-1:0] lim_rd_reg;

    logic [1:0]            state_reg, state_next;
    logic [NUM_TIMERS-1:0] armed_reg, armed_next;
    logic [NUM_TIMERS-1:0] act_reg, act_next;
    logic [IDX_W-1:0]      walk_idx_reg, walk_idx_next;
    logic                  stg_vld_reg, stg_vld_next;
    logic [IDX_W-1:0]      stg_idx_reg, stg_idx_next;
    logic                  pend_vld_reg, pend_vld_next;
    logic [IDX_W-1:0]      pend_idx_reg, pend_idx_next;
    logic                  strobe_reg, strobe_next;
    logic [INDEX_W-1:0]    fired_idx_reg, fired_idx_next;
    logic                  last_reg, last_next;

    logic                  rd_en;
    logic                  start_wr;
    logic                  cnt_wr;
    logic [COUNT_WIDTH:0]  cnt_ext;
    logic                  stg_live;
    logic                  stg_fires;

    // stage after the memory read: count up and test for expiry
    assign cnt_ext   = {1'b0, cnt_rd_reg} + (COUNT_WIDTH + 1)'(1);
    assign stg_live  = stg_vld_reg && armed_reg[stg_idx_reg];
    assign cnt_wr    = stg_live && (cnt_rd_reg < lim_rd_reg);
    assign stg_fires = stg_live && act_reg[stg_idx_reg] && (cnt_ext >= {1'b0, lim_rd_reg});

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        armed_next     = armed_reg;
        act_next       = act_reg;
        walk_idx_next  = walk_idx_reg;
        stg_vld_next   = 1'b0;
        stg_idx_next   = stg_idx_reg;
        pend_vld_next  = pend_vld_reg;
        pend_idx_next  = pend_idx_reg;
        strobe_next    = 1'b0;
        fired_idx_next = fired_idx_reg;
        last_next      = 1'b0;
        rd_en          = 1'b0;
        start_wr       = 1'b0;
        cmd_pop        = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd.valid)
                begin
                    cmd_pop = 1'b1;
                    unique case (cmd.kind)
                        CMD_TICK:
                        begin
                            state_next    = S_WALK;
                            walk_idx_next = '0;
                        end
                        CMD_START:
                        begin
                            start_wr            = 1'b1;
                            armed_next[cmd_idx] = 1'b1;
                            act_next[cmd_idx]   = cmd.act;
                            if ((cmd_limit == '0) && cmd.act)
                            begin
                                strobe_next    = 1'b1;
                                fired_idx_next = INDEX_W'(cmd_idx);
                                last_next      = 1'b1;
                            end
                        end
                        default:
                        begin
                            armed_next[cmd_idx] = 1'b0;
                            act_next[cmd_idx]   = 1'b0;
                        end
                    endcase
                end
            end
            S_WALK:
            begin
                rd_en        = 1'b1;
                stg_vld_next = 1'b1;
                stg_idx_next = walk_idx_reg;
                if (walk_idx_reg == LAST_IDX)
                begin
                    state_next = S_DRAIN;
                end
                else
                begin
                    walk_idx_next = IDX_W'(walk_idx_reg + 1'b1);
                end
            end
            S_DRAIN:
            begin
                state_next = S_FINAL;
            end
            default:
            begin
                // the held fire word is the final one of this tick
                if (pend_vld_reg)
                begin
                    strobe_next    = 1'b1;
                    fired_idx_next = INDEX_W'(pend_idx_reg);
                    last_next      = 1'b1;
                end
                pend_vld_next = 1'b0;
                state_next    = S_IDLE;
            end
        endcase

        // a new expiry releases the held word, which is then not the last
        if (stg_fires)
        begin
            if (pend_vld_reg)
            begin
                strobe_next    = 1'b1;
                fired_idx_next = INDEX_W'(pend_idx_reg);
                last_next      = 1'b0;
            end
            pend_vld_next = 1'b1;
            pend_idx_next = stg_idx_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            armed_reg    <= '0;
            act_reg      <= '0;
            walk_idx_reg <= '0;
            stg_vld_reg  <= 1'b0;
            pend_vld_reg <= 1'b0;
            strobe_reg   <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            armed_reg    <= armed_next;
            act_reg      <= act_next;
            walk_idx_reg <= walk_idx_next;
            stg_vld_reg  <= stg_vld_next;
            pend_vld_reg <= pend_vld_next;
            strobe_reg   <= strobe_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        stg_idx_reg   <= stg_idx_next;
        pend_idx_reg  <= pend_idx_next;
        fired_idx_reg <= fired_idx_next;
        last_reg      <= last_next;
    end

    // memory ports: one write, one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (start_wr)
        begin
            lim_mem[cmd_idx] <= cmd_limit;
            cnt_mem[cmd_idx] <= '0;
        end
        else if (cnt_wr)
        begin
            cnt_mem[stg_idx_reg] <= cnt_ext[COUNT_WIDTH-1:0];
        end
        if (rd_en)
        begin
            cnt_rd_reg <= cnt_mem[walk_idx_reg];
            lim_rd_reg <= lim_mem[walk_idx_reg];
        end
    end

    assign strobe      = strobe_reg;
    assign fired_index = fired_idx_reg;
    assign last        = last_reg;

endmodule

// ----- hw/rtl/periodic_timer_task_bank.sv -----
// top level of the periodic timer bank
//
//  channel   handshake          word
//  -------   ----------------   --------------------------------------------
//  command   start / busy       op, timer_index, count_limit, has_action
//  fire      strobe (no stall)  fired_index, last
//
// start and stop are carried out in the back end as they are popped; a tick
// pops, walks the timers reading one count/limit memory entry per cycle,
// drains the read stage and then gives the final word.
// a two-word command queue sits between front and back; busy is high while
// it is full. reset clears the armed and action bits but not the count and
// limit memories, which need no clearing pass. fire words cannot be held off.
`timescale 1ns / 1ps

module periodic_timer_task_bank #(
    parameter int NUM_TIMERS  = ptb_pkg::NUM_TIMERS_DEF,
    parameter int COUNT_WIDTH = ptb_pkg::COUNT_WIDTH_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [ptb_pkg::OP_W-1:0]    op,
    input  logic [ptb_pkg::INDEX_W-1:0] timer_index,
    input  logic [ptb_pkg::LIMIT_W-1:0] count_limit,
    input  logic                        has_action,
    output logic                        strobe,
    output logic [ptb_pkg::INDEX_W-1:0] fired_index,
    output logic                        last
);
    import ptb_pkg::*;

    localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

    cmd_ctl_t               cmd;
    logic [IDX_W-1:0]       cmd_idx;
    logic [COUNT_WIDTH-1:0] cmd_limit;
    logic                   cmd_pop;

    // decode and queue
    ptb_front #(
        .NUM_TIMERS  (NUM_TIMERS),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .op          (op),
        .timer_index (timer_index),
        .count_limit (count_limit),
        .has_action  (has_action),
        .busy        (busy),
        .cmd         (cmd),
        .cmd_idx     (cmd_idx),
        .cmd_limit   (cmd_limit),
        .cmd_pop     (cmd_pop)
    );

    // timer state and fire words
    ptb_back #(
        .NUM_TIMERS  (NUM_TIMERS),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .cmd_idx     (cmd_idx),
        .cmd_limit   (cmd_limit),
        .cmd_pop     (cmd_pop),
        .strobe      (strobe),
        .fired_index (fired_index),
        .last        (last)
    );

endmodule

// ----- hw/rtl/ptb_checker.sv -----
// port checker for the periodic timer bank, bound to the top level
`timescale 1ns / 1ps
`include "periodic_timer_task_bank_macros.svh"

module ptb_checker #(
    parameter int NUM_TIMERS = ptb_pkg::NUM_TIMERS_DEF
) (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        start,
    input logic                        busy,
    input logic [ptb_pkg::INDEX_W-1:0] fired_index,
    input logic                        strobe,
    input logic                        last
);
    import ptb_pkg::*;

    // the queue only fills on an accepted word
    `PTB_ASSERT_IMPLY(a_busy_from_accept, clk, rst_n, $rose(busy), $past(start))

    // a fire word names a timer of the bank
    `PTB_ASSERT_IMPLY(a_index_in_bank, clk, rst_n, strobe,
        {1'b0, fired_index} < (INDEX_W + 1)'(NUM_TIMERS))

    // the end mark only rides on a fire word
    `PTB_ASSERT_IMPLY(a_last_with_strobe, clk, rst_n, last, strobe)

    // with room in the queue and no word offered, the queue cannot become full
    `PTB_ASSERT_NEXT(a_full_needs_word, clk, rst_n, !busy && !start, !busy)

endmodule

bind periodic_timer_task_bank ptb_checker #(
    .NUM_TIMERS (NUM_TIMERS)
) u_ptb_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .fired_index (fired_index),
    .strobe      (strobe),
    .last        (last)
);

// ----- bench/periodic_timer_task_bank_test.sv -----
// self-checking testbench for the periodic timer bank
`timescale 1ns / 1ps

module periodic_timer_task_bank_test;

    import ptb_pkg::*;

    localparam int NUM_TIMERS     = NUM_TIMERS_DEF;
    localparam int COUNT_WIDTH    = COUNT_WIDTH_DEF;
    localparam int TICK_CYCLES    = NUM_TIMERS + 3;
    localparam int WATCHDOG_LIMIT = 2000;

    // op code the block does not decode
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    typedef struct {
        logic [INDEX_W-1:0] idx;
        logic               last_flag;
    } fire_word_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   start = 1'b0;
    logic                   busy;
    logic [OP_W-1:0]        op = OP_TICK;
    logic [INDEX_W-1:0]     timer_index = '0;
    logic [LIMIT_W-1:0]     count_limit = '0;
    logic                   has_action = 1'b0;
    logic                   strobe;
    logic [INDEX_W-1:0]     fired_index;
    logic                   last;

    // mirror of the timer bank
    logic                   mdl_armed [NUM_TIMERS];
    logic [COUNT_WIDTH-1:0] mdl_count [NUM_TIMERS];
    logic [COUNT_WIDTH-1:0] mdl_limit [NUM_TIMERS];
    logic                   mdl_action [NUM_TIMERS];

    fire_word_t pending_fires[$];
    int         mismatch_count = 0;
    int         quiet_cycles = 0;

    periodic_timer_task_bank #(
        .NUM_TIMERS  (NUM_TIMERS),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .op          (op),
        .timer_index (timer_index),
        .count_limit (count_limit),
        .has_action  (has_action),
        .strobe      (strobe),
        .fired_index (fired_index),
        .last        (last)
    );

    always #1 clk = ~clk;

    // update the mirror and queue the fire words one command causes
    task automatic predict_fires(input logic [OP_W-1:0] w_op, input logic [INDEX_W-1:0] w_idx,
                                 input logic [LIMIT_W-1:0] w_lim, input logic w_act);
        fire_word_t batch[$];
        fire_word_t fw;
        if (w_op == OP_TICK) begin
            for (int t = 0; t < NUM_TIMERS; t++) begin
                if (mdl_armed[t]) begin
                    if (mdl_count[t] < mdl_limit[t])
                        mdl_count[t] = mdl_count[t] + 1'b1;
                    if (mdl_count[t] >= mdl_limit[t] && mdl_action[t]) begin
                        fw.idx = INDEX_W'(t);
                        fw.last_flag = 1'b0;
                        batch.push_back(fw);
                    end
                end
            end
            if (batch.size() > 0)
                batch[batch.size() - 1].last_flag = 1'b1;
        end else if (w_idx < NUM_TIMERS) begin
            if (w_op == OP_START) begin
                mdl_armed[w_idx] = 1'b1;
                mdl_limit[w_idx] = COUNT_WIDTH'(w_lim);
                mdl_count[w_idx] = '0;
                mdl_action[w_idx] = w_act;
                if (COUNT_WIDTH'(w_lim) == '0 && w_act) begin
                    fw.idx = w_idx;
                    fw.last_flag = 1'b1;
                    batch.push_back(fw);
                end
            end else if (w_op == OP_STOP) begin
                mdl_armed[w_idx] = 1'b0;
                mdl_count[w_idx] = '0;
                mdl_action[w_idx] = 1'b0;
            end
        end
        foreach (batch[i])
            pending_fires.push_back(batch[i]);
    endtask

    // present one command word and hold it until the block takes it
    task automatic send_word(input logic [OP_W-1:0] w_op, input logic [INDEX_W-1:0] w_idx,
                             input logic [LIMIT_W-1:0] w_lim, input logic w_act);
        start <= 1'b1;
        op <= w_op;
        timer_index <= w_idx;
        count_limit <= w_lim;
        has_action <= w_act;
        do
            @(posedge clk);
        while (busy);
        predict_fires(w_op, w_idx, w_lim, w_act);
    endtask

    // drop start for a while, with junk on the payload
    task automatic idle_burst(input int cycles);
        start <= 1'b0;
        op <= OP_W'($urandom_range(0, 3));
        timer_index <= INDEX_W'($urandom_range(0, 63));
        count_limit <= LIMIT_W'($urandom());
        has_action <= 1'($urandom_range(0, 1));
        repeat (cycles) @(posedge clk);
    endtask

    task automatic test_idle_tick();
        send_word(OP_TICK, 6'd0, 32'd0, 1'b0);
    endtask

    // zero limit with action fires at once, without action stays quiet; nonzero limits arm without firing
    task automatic test_immediate_fire();
        send_word(OP_START, 6'd0, 32'd0, 1'b1);
        send_word(OP_START, 6'd1, 32'd0, 1'b0);
        send_word(OP_START, 6'd2, 32'hFFFF_FFFF, 1'b1);
        send_word(OP_START, 6'd7, 32'd2, 1'b1);
    endtask

    // indexes past the bank and the unused op change nothing
    task automatic test_ignored_words();
        send_word(OP_START, 6'd8, 32'd0, 1'b1);
        send_word(OP_START, 6'd63, 32'd0, 1'b1);
        send_word(OP_STOP, 6'd63, 32'hFFFF_FFFF, 1'b1);
        send_word(OP_UNUSED, 6'd1, 32'd0, 1'b1);
    endtask

    // counting up to the limit, holding there, and stopping
    task automatic test_expiry_and_saturation();
        repeat (3) send_word(OP_TICK, 6'd63, 32'hFFFF_FFFF, 1'b1);
        send_word(OP_START, 6'd3, 32'd1, 1'b1);
        send_word(OP_STOP, 6'd0, 32'd0, 1'b0);
        send_word(OP_TICK, 6'd0, 32'd0, 1'b0);
        send_word(OP_STOP, 6'd7, 32'd0, 1'b0);
        send_word(OP_TICK, 6'd0, 32'd0, 1'b0);
    endtask

    // every timer firing on one tick
    task automatic test_full_bank();
        for (int t = 0; t < NUM_TIMERS; t++)
            send_word(OP_START, INDEX_W'(t), 32'd0, 1'b1);
        send_word(OP_TICK, 6'd0, 32'd0, 1'b0);
    endtask

    // mixed traffic, with or without idle gaps
    task automatic run_random_traffic(input int n_words, input bit with_gaps);
        int                 sent;
        int                 r;
        int                 pick;
        logic [OP_W-1:0]    w_op;
        logic [INDEX_W-1:0] w_idx;
        logic [LIMIT_W-1:0] w_lim;
        logic               w_act;
        sent = 0;
        while (sent < n_words) begin
            if (with_gaps && $urandom_range(0, 2) == 0)
                idle_burst($urandom_range(1, 19));
            r = $urandom_range(0, 99);
            w_idx = INDEX_W'($urandom_range(0, NUM_TIMERS - 1));
            w_lim = LIMIT_W'($urandom());
            w_act = 1'($urandom_range(0, 1));
            if (r < 45) begin
                w_op = OP_TICK;
                w_idx = INDEX_W'($urandom_range(0, 63));
            end else if (r < 80) begin
                w_op = OP_START;
                pick = $urandom_range(0, 9);
                if (pick < 2)
                    w_lim = '0;
                else if (pick < 7)
                    w_lim = LIMIT_W'($urandom_range(1, 6));
                else if (pick == 7)
                    w_lim = LIMIT_W'($urandom_range(7, 40));
                else if (pick == 9)
                    w_lim = '1;
                w_act = ($urandom_range(0, 3) != 0);
            end else if (r < 92) begin
                w_op = OP_STOP;
            end else if ($urandom_range(0, 1) == 0) begin
                w_op = OP_UNUSED;
                w_idx = INDEX_W'($urandom_range(0, 63));
            end else begin
                w_op = ($urandom_range(0, 1) == 0) ? OP_START : OP_STOP;
                w_idx = INDEX_W'($urandom_range(NUM_TIMERS, 63));
            end
            send_word(w_op, w_idx, w_lim, w_act);
            sent++;
        end
    endtask

    // compare each fire word with the oldest expected one
    always @(posedge clk) begin
        fire_word_t want;
        if (rst_n && strobe) begin
            if (pending_fires.size() == 0) begin
                $display("%0t: unexpected fire word, expected none, actual index %0d last %0b",
                         $time, fired_index, last);
                mismatch_count++;
            end else begin
                want = pending_fires.pop_front();
                if (fired_index !== want.idx) begin
                    $display("%0t: fired_index expected %0d actual %0d",
                             $time, want.idx, fired_index);
                    mismatch_count++;
                end
                if (last !== want.last_flag) begin
                    $display("%0t: last expected %0b actual %0b", $time, want.last_flag, last);
                    mismatch_count++;
                end
            end
        end
    end

    // watchdog on cycles with no word moving either way
    always @(posedge clk) begin
        if (!rst_n || (start && !busy) || strobe) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        for (int t = 0; t < NUM_TIMERS; t++)
        begin
            mdl_armed[t] = 1'b0;
            mdl_count[t] = '0;
            mdl_limit[t] = '0;
            mdl_action[t] = 1'b0;
        end
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_idle_tick();
        test_immediate_fire();
        test_ignored_words();
        test_expiry_and_saturation();
        test_full_bank();
        run_random_traffic(220, 1'b1);
        run_random_traffic(80, 1'b0);

        // drain, then let any silent tick walk finish
        start <= 1'b0;
        while (pending_fires.size() != 0)
            @(posedge clk);
        repeat (4 * TICK_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
